// ===== src/mom_sel_pkg.sv =====
// package for the median-of-means pixel select block
// holds field widths, window depth default and the item structs; no dependencies
package mom_sel_pkg;

  localparam int unsigned MaxWindowDefault = 16;
  localparam int unsigned DataW = 32;

  typedef struct packed {
    logic [31:0]        red_value;
    logic [31:0]        green_value;
    logic [31:0]        blue_value;
    logic [31:0]        buffer_weight;
    logic signed [31:0] red_splat;
    logic signed [31:0] green_splat;
    logic signed [31:0] blue_splat;
    logic               last_buffer;
  } in_item_t;

  typedef struct packed {
    logic [31:0]        red_median;
    logic [31:0]        green_median;
    logic [31:0]        blue_median;
    logic [31:0]        median_weight;
    logic signed [31:0] red_splat_out;
    logic signed [31:0] green_splat_out;
    logic signed [31:0] blue_splat_out;
    logic               overflow_flag;
  } out_item_t;

  // control from the sequencer to the rank lanes
  typedef struct packed {
    logic clear;    // end of a window; drops all entries
    logic insert;   // new entry arrives this cycle
  } lane_ctrl_t;

endpackage

// ===== src/median_of_means_pixel_select_core.sv =====
// top level of the median-of-means pixel select block
// depends on mom_sel_pkg, mom_sel_lane and mom_sel_merge
//
//  channel | valid     | stall     | payload
//  in      | in_valid_i| in_stall_o| in_item_i  (mom_sel_pkg::in_item_t)
//  out     | out_valid_o| out_stall_i| out_item_o (mom_sel_pkg::out_item_t)
//
// a buffer without the last flag is only inserted (only counted, once full); three rank lanes update
// running ranks on arrival, so each item compares against all stored entries once
// a last buffer goes through insert, gather picks and sum weights, then divide
// the divide-by-three multiply has its own state; result sits in an output register
// reset clears the count, lane valid bits and handshake state; stores hold no reset
// input stalls while a result is pending or being formed
module median_of_means_pixel_select_core #(
  parameter int unsigned MaxWindow = mom_sel_pkg::MaxWindowDefault
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  mom_sel_pkg::in_item_t  in_item_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output mom_sel_pkg::out_item_t out_item_o
);

  localparam int unsigned IdxW = (MaxWindow > 1) ? $clog2(MaxWindow) : 1;
  localparam int unsigned CntW = $clog2(MaxWindow + 2);
  localparam logic [CntW-1:0] Full = CntW'(MaxWindow);
  localparam logic [CntW-1:0] Over = CntW'(MaxWindow + 1);

  localparam logic [1:0] StIdle   = 2'd0;
  localparam logic [1:0] StGather = 2'd1;
  localparam logic [1:0] StDiv    = 2'd2;

  logic [1:0]      state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic            accept, do_insert;
  logic            over_q;
  logic [CntW-1:0] target_q;

  // payload stores, indexed by the lane picks
  logic [31:0] w_mem [MaxWindow];
  logic [31:0] rs_mem [MaxWindow];
  logic [31:0] gs_mem [MaxWindow];
  logic [31:0] bs_mem [MaxWindow];
  logic [31:0] rv_mem [MaxWindow];
  logic [31:0] gv_mem [MaxWindow];
  logic [31:0] bv_mem [MaxWindow];

  mom_sel_pkg::lane_ctrl_t ctrl;
  logic [IdxW-1:0] pick_r, pick_g, pick_b;
  logic [31:0]     mean;
  mom_sel_pkg::out_item_t res_q;
  logic            out_valid_q;

  assign in_stall_o = (state_q != StIdle) || out_valid_q;
  assign accept     = in_valid_i && !in_stall_o;
  assign do_insert  = accept && (count_q < Full);

  // lanes drop their entries together with the count reset at the end of a window
  assign ctrl.clear  = (state_q == StDiv);
  assign ctrl.insert = do_insert;

  always_comb begin
    count_d = count_q;
    state_d = state_q;
    if (accept) begin
      if (count_q <= Full) count_d = count_q + 1'b1;
      if (in_item_i.last_buffer) state_d = StGather;
    end
    case (state_q)
      StGather: state_d = StDiv;
      StDiv:    begin
        state_d = StIdle;
        count_d = '0;
      end
      default:  ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (state_q == StDiv) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_insert) begin
      w_mem[count_q[IdxW-1:0]]  <= in_item_i.buffer_weight;
      rs_mem[count_q[IdxW-1:0]] <= in_item_i.red_splat;
      gs_mem[count_q[IdxW-1:0]] <= in_item_i.green_splat;
      bs_mem[count_q[IdxW-1:0]] <= in_item_i.blue_splat;
      rv_mem[count_q[IdxW-1:0]] <= in_item_i.red_value;
      gv_mem[count_q[IdxW-1:0]] <= in_item_i.green_value;
      bv_mem[count_q[IdxW-1:0]] <= in_item_i.blue_value;
    end
    if (accept && in_item_i.last_buffer) begin
      // count after this item, capped at the depth
      over_q   <= (count_q >= Full);
      target_q <= ((count_q >= Full) ? Full : (count_q + 1'b1)) >> 1;
    end
  end

  // rank lanes, one per color channel; lanes clear by the sequencer's count reset
  mom_sel_lane #(.MaxWindow(MaxWindow)) u_lane_r (
    .clk_i, .rst_ni, .ctrl_i(ctrl), .wr_idx_i(count_q[IdxW-1:0]),
    .value_i(in_item_i.red_value), .target_i(target_q), .pick_o(pick_r));
  mom_sel_lane #(.MaxWindow(MaxWindow)) u_lane_g (
    .clk_i, .rst_ni, .ctrl_i(ctrl), .wr_idx_i(count_q[IdxW-1:0]),
    .value_i(in_item_i.green_value), .target_i(target_q), .pick_o(pick_g));
  mom_sel_lane #(.MaxWindow(MaxWindow)) u_lane_b (
    .clk_i, .rst_ni, .ctrl_i(ctrl), .wr_idx_i(count_q[IdxW-1:0]),
    .value_i(in_item_i.blue_value), .target_i(target_q), .pick_o(pick_b));

  mom_sel_merge u_merge (
    .clk_i, .start_i(state_q == StGather),
    .w_r_i(w_mem[pick_r]), .w_g_i(w_mem[pick_g]), .w_b_i(w_mem[pick_b]),
    .mean_o(mean));

  // gather the picked fields, then add the weight mean in the divide state
  always_ff @(posedge clk_i) begin
    if (state_q == StGather) begin
      res_q.red_median      <= rv_mem[pick_r];
      res_q.green_median    <= gv_mem[pick_g];
      res_q.blue_median     <= bv_mem[pick_b];
      res_q.red_splat_out   <= rs_mem[pick_r];
      res_q.green_splat_out <= gs_mem[pick_g];
      res_q.blue_splat_out  <= bs_mem[pick_b];
      res_q.overflow_flag   <= over_q;
    end
    if (state_q == StDiv) res_q.median_weight <= mean;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = res_q;

  // the count never passes the saturation mark
  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= Over) else $error("count past saturation");
  // a result appears only after the divide step
  a_valid_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == StDiv) else $error("spurious result");
  // no item is taken while a result waits
  a_no_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !accept) else $error("item taken with result pending");

endmodule

// ===== src/mom_sel_lane.sv =====
// one rank lane: keeps a running stable rank for every stored entry of one channel
// depends on mom_sel_pkg
module mom_sel_lane #(
  parameter int unsigned MaxWindow = mom_sel_pkg::MaxWindowDefault,
  localparam int unsigned IdxW = (MaxWindow > 1) ? $clog2(MaxWindow) : 1,
  localparam int unsigned CntW = $clog2(MaxWindow + 2)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  mom_sel_pkg::lane_ctrl_t ctrl_i,
  input  logic [IdxW-1:0]        wr_idx_i,
  input  logic [31:0]            value_i,
  input  logic [CntW-1:0]        target_i,
  output logic [IdxW-1:0]        pick_o
);

  logic [31:0]     val_q [MaxWindow];
  logic [CntW-1:0] rank_q [MaxWindow];
  logic [MaxWindow-1:0] used_q;
  logic [CntW-1:0] new_rank;

  // new entry arrives last, so every stored entry not above it ranks below it
  always_comb begin
    new_rank = '0;
    for (int i = 0; i < MaxWindow; i++) begin
      if (used_q[i] && val_q[i] <= value_i) new_rank = new_rank + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
    end else if (ctrl_i.clear) begin
      used_q <= '0;
    end else if (ctrl_i.insert) begin
      used_q[wr_idx_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.insert && !ctrl_i.clear) begin
      for (int i = 0; i < MaxWindow; i++) begin
        if (used_q[i] && val_q[i] > value_i) rank_q[i] <= rank_q[i] + 1'b1;
      end
      val_q[wr_idx_i]  <= value_i;
      rank_q[wr_idx_i] <= new_rank;
    end
  end

  // exactly one used entry holds the target rank
  always_comb begin
    pick_o = '0;
    for (int i = 0; i < MaxWindow; i++) begin
      if (used_q[i] && rank_q[i] == target_i) pick_o = IdxW'(i);
    end
  end

endmodule

// ===== src/mom_sel_merge.sv =====
// merging stage: sums the weights of the three lanes' chosen entries and averages them
// no dependencies
module mom_sel_merge (
  input  logic        clk_i,
  input  logic        start_i,
  input  logic [31:0] w_r_i,
  input  logic [31:0] w_g_i,
  input  logic [31:0] w_b_i,
  output logic [31:0] mean_o
);

  logic [33:0] sum_q;
  logic [69:0] prod;

  always_ff @(posedge clk_i) begin
    if (start_i) sum_q <= 34'(w_r_i) + 34'(w_g_i) + 34'(w_b_i);
  end

  // divide by three: multiply by ceil(2^35/3) and shift, exact for 34-bit sums
  assign prod   = 70'(sum_q) * 70'(36'h2AAAAAAAB);
  assign mean_o = prod[66:35];

endmodule
